// ----- hdl/sabo_pkg.sv -----
// ============================================================================
// sabo_pkg - shared types and constants for the sprite alpha blend overlay
// Pixel layout, request codes, register indexes and control groups.
// ============================================================================
package sabo_pkg;

    // request kinds carried in tuser of the input stream
    typedef enum logic [1:0] {
        REQ_LOAD  = 2'd0,
        REQ_BLEND = 2'd1,
        REQ_READ  = 2'd2
    } req_t;

    // blue in the lowest byte, red in the highest
    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } pix_t;

    // classification of one word as it travels from front to back
    typedef struct packed {
        req_t req;
        logic hit;
    } ctrl_t;

    // queue status seen by both ends
    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_BG_WIDTH      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BG_HEIGHT     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPRITE_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPRITE_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y      = 3'd5;
    localparam int unsigned CFG_DATA_W = 10;

    // register reset values
    localparam logic [8:0] BG_SIDE_RST     = 9'd256;
    localparam logic [6:0] SPRITE_SIDE_RST = 7'd64;

    // signed width of the position arithmetic, covers sizes up to 4096
    localparam int unsigned CW = 14;

    localparam logic [7:0] ALPHA_MAX = 8'd255;

endpackage

// ----- hdl/sprite_alpha_blend_overlay.sv -----
// ============================================================================
// sprite_alpha_blend_overlay - alpha blend of a BGRA sprite onto a BGR frame
//
//  channel   dir  handshake                      contents
//  s_axis    in   s_axis_tvalid / s_axis_tready  load, blend or read request
//  m_axis    out  m_axis_tvalid / m_axis_tready  pixel and accepted flag
//  cfg       in   cfg_valid / cfg_ready          register index and value
//
//  Each word passes through three back-end steps (store read, mix products,
//  divide and write back); the back end finishes one word before it takes
//  the next, so a blend never reads a pixel that is still being written.
//  The front classifies one word per cycle into a 4-word queue while it is not
//  full, so input keeps flowing while the back end or the output stalls.
//  Reset clears control state and registers; the frame store is undefined
//  until loaded. cfg is always ready.
// ============================================================================
module sprite_alpha_blend_overlay #(
    parameter int unsigned MAX_BG_WIDTH    = 256,
    parameter int unsigned MAX_BG_HEIGHT   = 256,
    parameter int unsigned MAX_SPRITE_SIDE = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [sabo_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sabo_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // col[7:0], row[15:8], chan_b[23:16], chan_g[31:24], chan_r[39:32],
    // alpha[47:40]
    input  logic [47:0]                     s_axis_tdata,
    // req_type[1:0]
    input  logic [1:0]                      s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // out_b[7:0], out_g[15:8], out_r[23:16]
    output logic [23:0]                     m_axis_tdata,
    // accepted[0]
    output logic [0:0]                      m_axis_tuser
);
    import sabo_pkg::*;

    localparam int unsigned AW        = $clog2(MAX_BG_WIDTH * MAX_BG_HEIGHT);
    localparam int unsigned MEM_DEPTH = MAX_BG_WIDTH * MAX_BG_HEIGHT;
    localparam int unsigned QW        = $bits(ctrl_t) + AW + $bits(pix_t) + 8;
    localparam int unsigned Q_DEPTH   = 4;

    ctrl_t         f_ctrl, q_ctrl;
    logic [AW-1:0] f_addr, q_addr;
    pix_t          in_pix, q_pix, m_pix;
    logic [7:0]    q_alpha;
    logic [QW-1:0] q_din, q_dout;
    qstat_t        qstat;
    logic          push, q_pop, m_hit;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = !qstat.full;
    assign push          = s_axis_tvalid && s_axis_tready;

    assign in_pix.b = s_axis_tdata[23:16];
    assign in_pix.g = s_axis_tdata[31:24];
    assign in_pix.r = s_axis_tdata[39:32];

    sabo_front #(
        .MAX_BG_WIDTH    (MAX_BG_WIDTH),
        .MAX_BG_HEIGHT   (MAX_BG_HEIGHT),
        .MAX_SPRITE_SIDE (MAX_SPRITE_SIDE),
        .AW              (AW)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_type  (s_axis_tuser),
        .col       (s_axis_tdata[7:0]),
        .row       (s_axis_tdata[15:8]),
        .ctrl      (f_ctrl),
        .addr      (f_addr)
    );

    assign q_din = {f_ctrl, f_addr, in_pix, s_axis_tdata[47:40]};

    sabo_fifo #(
        .WIDTH (QW),
        .DEPTH (Q_DEPTH)
    ) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (q_din),
        .pop   (q_pop),
        .dout  (q_dout),
        .stat  (qstat)
    );

    assign {q_ctrl, q_addr, q_pix, q_alpha} = q_dout;

    sabo_back #(
        .AW        (AW),
        .MEM_DEPTH (MEM_DEPTH)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .qstat   (qstat),
        .q_ctrl  (q_ctrl),
        .q_addr  (q_addr),
        .q_pix   (q_pix),
        .q_alpha (q_alpha),
        .pop     (q_pop),
        .m_valid (m_axis_tvalid),
        .m_ready (m_axis_tready),
        .m_pix   (m_pix),
        .m_hit   (m_hit)
    );

    assign m_axis_tdata    = m_pix;
    assign m_axis_tuser[0] = m_hit;

`ifndef SYNTHESIS
    // rejected words carry a black pixel
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == '0)
        else $error("rejected result carries non-zero pixel");

    // back end never takes from an empty queue
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !qstat.empty)
        else $error("queue popped while empty");

    // a fresh result follows a queue pop by the back end, through its read and finish states
    a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(q_pop, 3))
        else $error("result appeared without a matching pop");
`endif

endmodule

// ----- hdl/sabo_front.sv -----
// ============================================================================
// sabo_front - configuration registers and request classification
// Works out the frame address of each word and whether it lands inside.
// ============================================================================
module sabo_front #(
    parameter int unsigned MAX_BG_WIDTH    = 256,
    parameter int unsigned MAX_BG_HEIGHT   = 256,
    parameter int unsigned MAX_SPRITE_SIDE = 64,
    parameter int unsigned AW              = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr,
    input  logic [sabo_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sabo_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic [1:0]                      req_type,
    input  logic [7:0]                      col,
    input  logic [7:0]                      row,
    output sabo_pkg::ctrl_t                 ctrl,
    output logic [AW-1:0]                   addr
);
    import sabo_pkg::*;

    logic [8:0]        bg_width_reg;
    logic [8:0]        bg_height_reg;
    logic [6:0]        sprite_width_reg;
    logic [6:0]        sprite_height_reg;
    logic signed [9:0] center_x_reg;
    logic signed [9:0] center_y_reg;

    logic [CW-1:0]        w, h, sw, sh;
    logic [CW-1:0]        col_w, row_w;
    logic signed [CW-1:0] bx, by, w_m1, h_m1;
    logic [CW-1:0]        xsel, ysel;
    logic                 bg_hit, blend_hit, hit;
    req_t                 req;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bg_width_reg      <= BG_SIDE_RST;
            bg_height_reg     <= BG_SIDE_RST;
            sprite_width_reg  <= SPRITE_SIDE_RST;
            sprite_height_reg <= SPRITE_SIDE_RST;
            center_x_reg      <= '0;
            center_y_reg      <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_index)
                CFG_BG_WIDTH:      bg_width_reg      <= cfg_data[8:0];
                CFG_BG_HEIGHT:     bg_height_reg     <= cfg_data[8:0];
                CFG_SPRITE_WIDTH:  sprite_width_reg  <= cfg_data[6:0];
                CFG_SPRITE_HEIGHT: sprite_height_reg <= cfg_data[6:0];
                CFG_CENTER_X:      center_x_reg      <= $signed(cfg_data);
                CFG_CENTER_Y:      center_y_reg      <= $signed(cfg_data);
                default: ;
            endcase
        end
    end

    always_comb
    begin
        // clamp sizes to what the store and sprite limits allow
        w  = (CW'(bg_width_reg) > CW'(MAX_BG_WIDTH)) ? CW'(MAX_BG_WIDTH)
                                                    : CW'(bg_width_reg);
        h  = (CW'(bg_height_reg) > CW'(MAX_BG_HEIGHT)) ? CW'(MAX_BG_HEIGHT)
                                                      : CW'(bg_height_reg);
        sw = (CW'(sprite_width_reg) > CW'(MAX_SPRITE_SIDE)) ? CW'(MAX_SPRITE_SIDE)
                                                           : CW'(sprite_width_reg);
        sh = (CW'(sprite_height_reg) > CW'(MAX_SPRITE_SIDE)) ? CW'(MAX_SPRITE_SIDE)
                                                            : CW'(sprite_height_reg);
        col_w = CW'(col);
        row_w = CW'(row);

        bx   = CW'(center_x_reg) + $signed(col_w) - $signed({1'b0, sw[CW-1:1]});
        by   = CW'(center_y_reg) + $signed(row_w) - $signed({1'b0, sh[CW-1:1]});
        w_m1 = $signed(w) - $signed(CW'(1));
        h_m1 = $signed(h) - $signed(CW'(1));

        bg_hit    = (col_w < w) && (row_w < h);
        // border pixels stay untouched
        blend_hit = (col_w < sw) && (row_w < sh) &&
                    (bx > $signed(CW'(0))) && (by > $signed(CW'(0))) &&
                    (bx < w_m1) && (by < h_m1);

        req  = req_t'(req_type);
        xsel = col_w;
        ysel = row_w;
        unique case (req_type)
            REQ_LOAD, REQ_READ: hit = bg_hit;
            REQ_BLEND:
            begin
                hit  = blend_hit;
                xsel = bx;
                ysel = by;
            end
            default: hit = 1'b0;
        endcase

        ctrl.req = req;
        ctrl.hit = hit;
        addr = AW'(AW'(ysel) * AW'(MAX_BG_WIDTH) + AW'(xsel));
    end

endmodule

// ----- hdl/sabo_fifo.sv -----
// ============================================================================
// sabo_fifo - short word queue between front and back
// Register array with read and write pointers and a fill count.
// ============================================================================
module sabo_fifo #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output sabo_pkg::qstat_t stat
);
    import sabo_pkg::*;

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [PW:0]      count_reg;

    function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
        logic [PW-1:0] n;
        n = (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
        return n;
    endfunction

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= din;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= bump(wr_ptr_reg);
            if (pop)
                rd_ptr_reg <= bump(rd_ptr_reg);
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    assign dout       = slot_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == (PW+1)'(DEPTH));
    assign stat.empty = (count_reg == '0);

endmodule

// ----- hdl/sabo_back.sv -----
// ============================================================================
// sabo_back - frame store and pixel engine
// Read-modify-write of the frame store, alpha mix and result register.
// ============================================================================
module sabo_back #(
    parameter int unsigned AW        = 16,
    parameter int unsigned MEM_DEPTH = 65536
) (
    input  logic             clk,
    input  logic             rst_n,
    input  sabo_pkg::qstat_t qstat,
    input  sabo_pkg::ctrl_t  q_ctrl,
    input  logic [AW-1:0]    q_addr,
    input  sabo_pkg::pix_t   q_pix,
    input  logic [7:0]       q_alpha,
    output logic             pop,
    output logic             m_valid,
    input  logic             m_ready,
    output sabo_pkg::pix_t   m_pix,
    output logic             m_hit
);
    import sabo_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_FIN
    } state_t;

    state_t state_reg, state_next;

    pix_t          mem [MEM_DEPTH];
    ctrl_t         ctrl_reg;
    logic [AW-1:0] addr_reg;
    pix_t          pix_reg;
    logic [7:0]    alpha_reg;
    pix_t          old_reg;
    logic [15:0]   sum_b_reg, sum_g_reg, sum_r_reg;

    logic       out_valid_reg, out_valid_next;
    pix_t       out_pix_reg, out_pix_next;
    logic       out_hit_reg, out_hit_next;
    logic       out_free, wr_en;
    pix_t       mixed, result;
    logic [7:0] inv_alpha;

    // floor(v / 255) by reciprocal 257/65536, then one correction step
    function automatic logic [7:0] div255(input logic [15:0] v);
        logic [23:0] t;
        logic [7:0]  q;
        logic [15:0] rem;
        t   = {v, 8'b0} + {8'b0, v};
        q   = t[23:16];
        rem = v - ({q, 8'b0} - {8'b0, q});
        if (rem >= 16'd255)
            q = q + 1'b1;
        return q;
    endfunction

    assign pop       = (state_reg == S_IDLE) && !qstat.empty;
    assign out_free  = !out_valid_reg || m_ready;
    assign inv_alpha = ALPHA_MAX - alpha_reg;

    always_comb
    begin
        mixed.b = div255(sum_b_reg);
        mixed.g = div255(sum_g_reg);
        mixed.r = div255(sum_r_reg);
        result  = '0;
        if (ctrl_reg.hit)
        begin
            unique case (ctrl_reg.req)
                REQ_LOAD:  result = pix_reg;
                REQ_BLEND: result = mixed;
                REQ_READ:  result = old_reg;
                default:   result = '0;
            endcase
        end
        wr_en = (state_reg == S_FIN) && out_free && ctrl_reg.hit &&
                ((ctrl_reg.req == REQ_LOAD) || (ctrl_reg.req == REQ_BLEND));
    end

    // frame store and word capture
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            old_reg   <= mem[q_addr];
            ctrl_reg  <= q_ctrl;
            addr_reg  <= q_addr;
            pix_reg   <= q_pix;
            alpha_reg <= q_alpha;
        end
        if (state_reg == S_READ)
        begin
            sum_b_reg <= 16'(alpha_reg * pix_reg.b) + 16'(inv_alpha * old_reg.b);
            sum_g_reg <= 16'(alpha_reg * pix_reg.g) + 16'(inv_alpha * old_reg.g);
            sum_r_reg <= 16'(alpha_reg * pix_reg.r) + 16'(inv_alpha * old_reg.r);
        end
        if (wr_en)
            mem[addr_reg] <= result;
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        out_pix_next   = out_pix_reg;
        out_hit_next   = out_hit_reg;
        if (out_valid_reg && m_ready)
            out_valid_next = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (pop)
                    state_next = S_READ;
            end
            S_READ:
                state_next = S_FIN;
            S_FIN:
            begin
                // hold until the result register frees up
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_pix_next   = result;
                    out_hit_next   = ctrl_reg.hit;
                    state_next     = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            out_pix_reg   <= '0;
            out_hit_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            out_pix_reg   <= out_pix_next;
            out_hit_reg   <= out_hit_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_pix   = out_pix_reg;
    assign m_hit   = out_hit_reg;

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps
// ============================================================================
// tb_top - self-checking bench for the sprite alpha blend overlay
// Loads background pixels, blends sprite pixels over them and reads them back
// under a series of frame settings. Every word on the result stream is checked
// against a fixed want or a pixel-exact software copy of the store and registers.
// ============================================================================
module tb_top;
    import sabo_pkg::*;

    localparam int unsigned BG_MAX      = 256;
    localparam int unsigned SPR_MAX     = 64;
    localparam logic [1:0]  REQ_UNUSED  = 2'd3;
    localparam int unsigned ITEMS       = 1950;
    localparam int unsigned CYCLE_LIMIT = 400000;

    typedef struct packed {
        pix_t px;
        logic acc;
    } outcome_t;

    typedef struct {
        bit       fixed;
        outcome_t want;
    } answer_t;

    typedef struct {
        bit                    is_reg;
        logic [CFG_IDX_W-1:0]  idx;
        logic [9:0]            val;
        logic [1:0]            req;
        logic [7:0]            col;
        logic [7:0]            row;
        pix_t                  fg;
        logic [7:0]            a;
        bit                    fixed;
        outcome_t              want;
    } step_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [47:0]           s_axis_tdata = '0;
    logic [1:0]            s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [23:0]           m_axis_tdata;
    logic [0:0]            m_axis_tuser;

    // software copy of the block
    pix_t              frame_mem [BG_MAX*BG_MAX];
    bit                loaded [BG_MAX*BG_MAX];
    logic [8:0]        bgw_r = BG_SIDE_RST;
    logic [8:0]        bgh_r = BG_SIDE_RST;
    logic [6:0]        spw_r = SPRITE_SIDE_RST;
    logic [6:0]        sph_r = SPRITE_SIDE_RST;
    logic signed [9:0] cx_r = '0;
    logic signed [9:0] cy_r = '0;

    outcome_t pixel_due_q [$];
    answer_t  answer_q [$];
    int       errors = 0;
    bit       src_calm = 1'b0;
    int       src_left = 0;
    bit       snk_calm = 1'b0;
    int       snk_left = 0;

    sprite_alpha_blend_overlay dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("tb_top: done, errors");
        $finish;
    end

    function automatic void frame_dims(output int w, output int h, output int sw,
                                       output int sh);
        w  = (bgw_r > BG_MAX) ? BG_MAX : int'(bgw_r);
        h  = (bgh_r > BG_MAX) ? BG_MAX : int'(bgh_r);
        sw = (spw_r > SPR_MAX) ? SPR_MAX : int'(spw_r);
        sh = (sph_r > SPR_MAX) ? SPR_MAX : int'(sph_r);
    endfunction

    function automatic bit store_spot(input logic [7:0] col, input logic [7:0] row,
                                      output int unsigned addr);
        int w, h, sw, sh;
        frame_dims(w, h, sw, sh);
        addr = 0;
        if (int'(col) >= w || int'(row) >= h)
            return 1'b0;
        addr = row * BG_MAX + col;
        return 1'b1;
    endfunction

    // sprite pixel lands only strictly inside the one-pixel border
    function automatic bit blend_spot(input logic [7:0] col, input logic [7:0] row,
                                      output int unsigned addr);
        int w, h, sw, sh, x, y;
        frame_dims(w, h, sw, sh);
        addr = 0;
        if (int'(col) >= sw || int'(row) >= sh)
            return 1'b0;
        x = int'(cx_r) + int'(col) - sw / 2;
        y = int'(cy_r) + int'(row) - sh / 2;
        if (x <= 0 || y <= 0 || x >= w - 1 || y >= h - 1)
            return 1'b0;
        addr = y * BG_MAX + x;
        return 1'b1;
    endfunction

    function automatic logic [7:0] mix8(input logic [7:0] a, input logic [7:0] fg,
                                        input logic [7:0] bg);
        int unsigned t;
        t = a * fg + (255 - a) * bg;
        return 8'(t / 255);
    endfunction

    function automatic outcome_t overlay_apply(input logic [1:0] req,
                                               input logic [7:0] col,
                                               input logic [7:0] row,
                                               input pix_t fg, input logic [7:0] a);
        outcome_t    o;
        int unsigned addr;
        pix_t        old;
        o = '0;
        if (req == REQ_LOAD || req == REQ_READ)
        begin
            if (store_spot(col, row, addr))
            begin
                if (req == REQ_LOAD)
                begin
                    frame_mem[addr] = fg;
                    loaded[addr]    = 1'b1;
                end
                o.px  = frame_mem[addr];
                o.acc = 1'b1;
            end
        end
        else if (req == REQ_BLEND)
        begin
            if (blend_spot(col, row, addr))
            begin
                old             = frame_mem[addr];
                o.px.b          = mix8(a, fg.b, old.b);
                o.px.g          = mix8(a, fg.g, old.g);
                o.px.r          = mix8(a, fg.r, old.r);
                o.acc           = 1'b1;
                frame_mem[addr] = o.px;
            end
        end
        return o;
    endfunction

    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [9:0] val);
        case (idx)
            CFG_BG_WIDTH:      bgw_r = val[8:0];
            CFG_BG_HEIGHT:     bgh_r = val[8:0];
            CFG_SPRITE_WIDTH:  spw_r = val[6:0];
            CFG_SPRITE_HEIGHT: sph_r = val[6:0];
            CFG_CENTER_X:      cx_r  = val;
            CFG_CENTER_Y:      cy_r  = val;
            default: ;
        endcase
    endfunction

    function automatic step_t job(input logic [1:0] req, input logic [7:0] col,
                                  input logic [7:0] row, input pix_t fg,
                                  input logic [7:0] a);
        step_t s;
        s        = '{default: '0};
        s.req    = req;
        s.col    = col;
        s.row    = row;
        s.fg     = fg;
        s.a      = a;
        return s;
    endfunction

    function automatic step_t job_known(input logic [1:0] req, input logic [7:0] col,
                                        input logic [7:0] row, input pix_t fg,
                                        input logic [7:0] a, input pix_t px,
                                        input logic acc);
        step_t s;
        s          = job(req, col, row, fg, a);
        s.fixed    = 1'b1;
        s.want.px  = px;
        s.want.acc = acc;
        return s;
    endfunction

    function automatic step_t reg_step(input logic [CFG_IDX_W-1:0] idx,
                                       input logic [9:0] val);
        step_t s;
        s        = '{default: '0};
        s.is_reg = 1'b1;
        s.idx    = idx;
        s.val    = val;
        return s;
    endfunction

    task automatic note_mismatch(input string what, input int unsigned got_v,
                                 input int unsigned want_v);
        if (errors < 40)
            $display("%0t tb_top: mismatch on %s, got %0h want %0h",
                     $realtime, what, got_v, want_v);
        errors++;
    endtask

    task automatic drain();
        while (pixel_due_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [9:0] val);
        bit hs;
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do
        begin
            @(negedge clk);
            hs = cfg_ready;
            @(posedge clk);
        end
        while (!hs);
    endtask

    task automatic program_frame(input logic [9:0] bw, input logic [9:0] bh,
                                 input logic [9:0] sw, input logic [9:0] sh,
                                 input logic [9:0] cx, input logic [9:0] cy);
        reg_write(CFG_BG_WIDTH, bw);
        reg_write(CFG_BG_HEIGHT, bh);
        reg_write(CFG_SPRITE_WIDTH, sw);
        reg_write(CFG_SPRITE_HEIGHT, sh);
        reg_write(CFG_CENTER_X, cx);
        reg_write(CFG_CENTER_Y, cy);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_item(input logic [1:0] req, input logic [7:0] col,
                             input logic [7:0] row, input pix_t fg,
                             input logic [7:0] a, input bit fixed,
                             input outcome_t want);
        int gap;
        bit hs;
        if (src_left == 0)
        begin
            src_calm = ($urandom_range(0, 3) == 0);
            src_left = $urandom_range(10, 60);
        end
        src_left--;
        gap = src_calm ? 0 : $urandom_range(0, 14);
        answer_q.push_back('{fixed, want});
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tdata  <= {a, fg, row, col};
        s_axis_tuser  <= req;
        s_axis_tvalid <= 1'b1;
        do
        begin
            @(negedge clk);
            hs = s_axis_tready;
            @(posedge clk);
        end
        while (!hs);
    endtask

    // sample both streams mid-cycle, where every handshake signal is settled
    always @(negedge clk)
    begin
        outcome_t got;
        outcome_t due;
        answer_t  ans;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.px  = m_axis_tdata;
                got.acc = m_axis_tuser[0];
                if (pixel_due_q.size() == 0)
                    note_mismatch("result word with nothing due", got, 0);
                else
                begin
                    due = pixel_due_q.pop_front();
                    if (got.px.b !== due.px.b)
                        note_mismatch("out_b", got.px.b, due.px.b);
                    if (got.px.g !== due.px.g)
                        note_mismatch("out_g", got.px.g, due.px.g);
                    if (got.px.r !== due.px.r)
                        note_mismatch("out_r", got.px.r, due.px.r);
                    if (got.acc !== due.acc)
                        note_mismatch("accepted", got.acc, due.acc);
                end
            end
            if (cfg_valid && cfg_ready)
                apply_reg(cfg_index, cfg_data);
            if (s_axis_tvalid && s_axis_tready)
            begin
                due = overlay_apply(s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[15:8],
                                    s_axis_tdata[39:16], s_axis_tdata[47:40]);
                if (answer_q.size() != 0)
                begin
                    ans = answer_q.pop_front();
                    if (ans.fixed)
                        due = ans.want;
                end
                pixel_due_q.push_back(due);
            end
        end
    end

    // result sink: random back-pressure with calm stretches
    initial
    begin
        int stall;
        bit hs;
        @(posedge clk);
        forever
        begin
            if (snk_left == 0)
            begin
                snk_calm = ($urandom_range(0, 3) == 0);
                snk_left = $urandom_range(10, 60);
            end
            snk_left--;
            stall = snk_calm ? 0 : $urandom_range(0, 14);
            if (stall != 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do
            begin
                @(negedge clk);
                hs = m_axis_tvalid;
                @(posedge clk);
            end
            while (!hs);
        end
    end

    initial
    begin
        step_t       plan [$];
        step_t       s;
        int          w, h, sw, sh, pick, n, sent, phase, bw, bh, pw, ph;
        int unsigned addr;
        logic [1:0]  req;
        logic [7:0]  col, row, a;
        logic [9:0]  cx, cy;
        pix_t        fg;

        // reset-time frame: 256 x 256, 64 x 64 sprite centred on the origin
        plan.push_back(job_known(REQ_LOAD, 8'd0, 8'd0, 24'hffffff, 8'h00, 24'hffffff, 1'b1));
        plan.push_back(job_known(REQ_LOAD, 8'd255, 8'd255, 24'h000000, 8'hff, 24'h0, 1'b1));
        plan.push_back(job_known(REQ_LOAD, 8'd1, 8'd1, 24'h563412, 8'h5a, 24'h563412, 1'b1));
        plan.push_back(job_known(REQ_READ, 8'd0, 8'd0, 24'h0, 8'h00, 24'hffffff, 1'b1));
        plan.push_back(job_known(REQ_READ, 8'd255, 8'd255, 24'hffffff, 8'hff, 24'h0, 1'b1));
        plan.push_back(job_known(REQ_UNUSED, 8'd1, 8'd1, 24'habcdef, 8'h80, 24'h0, 1'b0));
        plan.push_back(job(REQ_BLEND, 8'd33, 8'd33, 24'ha09080, 8'hff));
        plan.push_back(job(REQ_BLEND, 8'd33, 8'd33, 24'h102030, 8'h00));
        plan.push_back(job(REQ_BLEND, 8'd33, 8'd33, 24'hff00ff, 8'h80));
        // left border, past the sprite edge, far outside
        plan.push_back(job_known(REQ_BLEND, 8'd32, 8'd33, 24'h123456, 8'hff, 24'h0, 1'b0));
        plan.push_back(job_known(REQ_BLEND, 8'd64, 8'd33, 24'h123456, 8'hff, 24'h0, 1'b0));
        plan.push_back(job_known(REQ_BLEND, 8'd255, 8'd255, 24'h123456, 8'hff, 24'h0, 1'b0));
        plan.push_back(job(REQ_READ, 8'd1, 8'd1, 24'h0, 8'h00));
        // 3 x 3 frame, single-pixel sprite on its only interior pixel
        plan.push_back(reg_step(CFG_BG_WIDTH, 10'd3));
        plan.push_back(reg_step(CFG_BG_HEIGHT, 10'd3));
        plan.push_back(reg_step(CFG_SPRITE_WIDTH, 10'd1));
        plan.push_back(reg_step(CFG_SPRITE_HEIGHT, 10'd1));
        plan.push_back(reg_step(CFG_CENTER_X, 10'd1));
        plan.push_back(reg_step(CFG_CENTER_Y, 10'd1));
        plan.push_back(job_known(REQ_LOAD, 8'd3, 8'd0, 24'h111111, 8'h00, 24'h0, 1'b0));
        plan.push_back(job_known(REQ_READ, 8'd0, 8'd3, 24'h0, 8'h00, 24'h0, 1'b0));
        plan.push_back(job_known(REQ_LOAD, 8'd2, 8'd2, 24'h332211, 8'h00, 24'h332211, 1'b1));
        plan.push_back(job(REQ_BLEND, 8'd0, 8'd0, 24'h0000ff, 8'd200));
        plan.push_back(job_known(REQ_BLEND, 8'd1, 8'd0, 24'h0000ff, 8'd200, 24'h0, 1'b0));
        // oversized widths, zero heights, extreme centres
        plan.push_back(reg_step(CFG_BG_WIDTH, 10'd511));
        plan.push_back(reg_step(CFG_BG_HEIGHT, 10'd0));
        plan.push_back(reg_step(CFG_SPRITE_WIDTH, 10'd127));
        plan.push_back(reg_step(CFG_SPRITE_HEIGHT, 10'd0));
        plan.push_back(reg_step(CFG_CENTER_X, 10'h200));
        plan.push_back(reg_step(CFG_CENTER_Y, 10'h1ff));
        plan.push_back(job_known(REQ_LOAD, 8'd255, 8'd0, 24'h777777, 8'h00, 24'h0, 1'b0));
        plan.push_back(job_known(REQ_READ, 8'd0, 8'd0, 24'h0, 8'h00, 24'h0, 1'b0));
        plan.push_back(job_known(REQ_BLEND, 8'd0, 8'd0, 24'h0, 8'hff, 24'h0, 1'b0));
        plan.push_back(reg_step(CFG_BG_HEIGHT, 10'd300));
        plan.push_back(reg_step(CFG_SPRITE_HEIGHT, 10'd127));
        plan.push_back(reg_step(CFG_CENTER_X, 10'd32));
        plan.push_back(reg_step(CFG_CENTER_Y, 10'd32));
        plan.push_back(job(REQ_BLEND, 8'd1, 8'd1, 24'h000000, 8'hff));
        plan.push_back(job(REQ_READ, 8'd255, 8'd255, 24'h0, 8'h00));

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            s = plan[i];
            if (s.is_reg)
            begin
                s_axis_tvalid <= 1'b0;
                drain();
                reg_write(s.idx, s.val);
            end
            else
            begin
                cfg_valid <= 1'b0;
                send_item(s.req, s.col, s.row, s.fg, s.a, s.fixed, s.want);
            end
        end

        sent  = 0;
        phase = 0;
        while (sent < ITEMS)
        begin
            s_axis_tvalid <= 1'b0;
            drain();
            case (phase)
                0: program_frame(10'd256, 10'd256, 10'd64, 10'd64, 10'd0, 10'd0);
                1: program_frame(10'd1, 10'd1, 10'd1, 10'd1, 10'h200, 10'h200);
                2: program_frame(10'd511, 10'd511, 10'd127, 10'd127, 10'h1ff, 10'h1ff);
                3: program_frame(10'd4, 10'd4, 10'd2, 10'd2, 10'd2, 10'd2);
                4: program_frame(10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0);
                default:
                begin
                    // mostly small frames and sprites so blends land on loaded pixels
                    bw = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 511) : $urandom_range(3, 24);
                    bh = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 511) : $urandom_range(3, 24);
                    pw = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 12);
                    ph = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 12);
                    cx = ($urandom_range(0, 7) == 0) ? 10'($urandom)
                                                     : 10'($urandom_range(0, (bw > 256) ? 256 : bw));
                    cy = ($urandom_range(0, 7) == 0) ? 10'($urandom)
                                                     : 10'($urandom_range(0, (bh > 256) ? 256 : bh));
                    program_frame(10'(bw), 10'(bh), 10'(pw), 10'(ph), cx, cy);
                end
            endcase
            n = $urandom_range(60, 140);
            repeat (n)
            begin
                frame_dims(w, h, sw, sh);
                pick = $urandom_range(0, 99);
                fg   = 24'($urandom);
                a    = ($urandom_range(0, 7) == 0) ? {8{1'($urandom)}} : 8'($urandom);
                if (pick < 35)
                    req = REQ_LOAD;
                else if (pick < 70)
                    req = REQ_BLEND;
                else if (pick < 95)
                    req = REQ_READ;
                else
                    req = REQ_UNUSED;
                if (req == REQ_BLEND && sw > 0 && sh > 0)
                begin
                    col = 8'($urandom_range(0, sw - 1));
                    row = 8'($urandom_range(0, sh - 1));
                end
                else if (req != REQ_BLEND && w > 0 && h > 0)
                begin
                    col = 8'($urandom_range(0, w - 1));
                    row = 8'($urandom_range(0, h - 1));
                end
                else
                begin
                    col = 8'($urandom);
                    row = 8'($urandom);
                end
                if ($urandom_range(0, 11) == 0)
                begin
                    col = 8'($urandom);
                    row = 8'($urandom);
                end
                // never touch a pixel that was never loaded: load it instead
                if (req == REQ_READ && store_spot(col, row, addr) && !loaded[addr])
                    req = REQ_LOAD;
                if (req == REQ_BLEND && blend_spot(col, row, addr) && !loaded[addr])
                begin
                    req = REQ_LOAD;
                    col = 8'(addr % BG_MAX);
                    row = 8'(addr / BG_MAX);
                end
                send_item(req, col, row, fg, a, 1'b0, '0);
                sent++;
            end
            phase++;
        end

        s_axis_tvalid <= 1'b0;
        drain();
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule
